>>> rtl/core/iot_pkg.sv
package iot_pkg;

	// id space and bitmap geometry
	localparam int MAX_ID   = 1023;
	localparam int ID_W     = 10;
	localparam int FREE_W   = 11;
	localparam int WORD_W   = 32;
	localparam int BIT_W    = $clog2(WORD_W);
	localparam int ROWS     = MAX_ID / WORD_W + 1;
	localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LAST_ROW = MAX_ID / WORD_W;
	localparam int LAST_BIT = MAX_ID % WORD_W;

	// request opcodes
	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_DEL = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_ABSENT = 2'd1,
		STAT_RANGE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_SCAN,
		ST_DONE
	} state_t;

	// index of the lowest set bit, zero when none
	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

	// index of the highest set bit, zero when none
	function automatic logic [BIT_W-1:0] highest_set(input logic [WORD_W-1:0] w);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

	// bits of a row that map to ids not above MAX_ID
	function automatic logic [WORD_W-1:0] range_mask(input logic [ROW_W-1:0] row);
		logic [WORD_W-1:0] m;
		m = '1;
		if (row == ROW_W'(LAST_ROW)) begin
			m = {WORD_W{1'b1}} >> (WORD_W - 1 - LAST_BIT);
		end
		return m;
	endfunction

endpackage

>>> rtl/core/id_occupancy_tracker_unit.sv
// channel  | signals                                     | dir | handshake
// ---------+---------------------------------------------+-----+------------------------
// request  | command, item_id                            | in  | start & !busy
// result   | status, was_present, lowest_free,           | out | done, one cycle, no stall
//          | highest_used                                |     |
//
// A request is accepted on start while busy is low. The bitmap row is read, updated
// and written back in one step; a scan for the new lowest free or highest used id
// then walks the bitmap one 32-bit row per cycle through the single RAM read port.
// An out-of-range id goes from idle straight to done. Reset clears the row valid
// flags, so unwritten rows read as empty and no clearing pass is needed. Results
// cannot be stalled.
module id_occupancy_tracker_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      command,
	input  logic [iot_pkg::ID_W-1:0]  item_id,
	output logic                      done,
	output logic [1:0]                status,
	output logic                      was_present,
	output logic [iot_pkg::FREE_W-1:0] lowest_free,
	output logic [iot_pkg::ID_W-1:0]  highest_used
);

	import iot_pkg::*;

	state_t              state_q, state_d;
	logic                cmd_q;
	logic [ID_W-1:0]     id_q;
	status_t             status_q;
	logic                was_present_q;
	logic [FREE_W-1:0]   first_free_q;
	logic [ID_W-1:0]     last_used_q;
	logic [ROW_W-1:0]    scan_row_q;
	logic                scan_up_q;
	logic [ROWS-1:0]     row_vld_q;
	logic                vld_rd_q;

	logic                accept;
	logic                in_range;
	logic                we;
	logic [ROW_W-1:0]    raddr;
	logic [WORD_W-1:0]   rdata;
	logic [WORD_W-1:0]   rword;
	logic [WORD_W-1:0]   onehot;
	logic [WORD_W-1:0]   wword;
	logic [WORD_W-1:0]   up_cand;
	logic [WORD_W-1:0]   dn_cand;
	logic [WORD_W-1:0]   scan_cand;
	logic [BIT_W-1:0]    bitpos;
	logic [ROW_W-1:0]    row;
	logic [ROW_W-1:0]    scan_next;
	logic                present;
	logic                need_up;
	logic                need_dn;
	logic                scan_end;

	assign accept   = start && !busy;
	assign in_range = (item_id != '0) && (item_id <= ID_W'(MAX_ID));

	// row under update and its word, invalid rows read as empty
	assign bitpos  = id_q[BIT_W-1:0];
	assign row     = ROW_W'(id_q >> BIT_W);
	assign rword   = rdata & {WORD_W{vld_rd_q}};
	assign onehot  = WORD_W'(1) << bitpos;
	assign present = |(rword & onehot);
	assign wword   = (cmd_q == CMD_ADD) ? (rword | onehot) : (rword & ~onehot);

	// search candidates within the updated row
	assign up_cand = ~wword & (({WORD_W{1'b1}} << bitpos) << 1) & range_mask(row);
	assign dn_cand = wword & (onehot - WORD_W'(1));

	// scans that run past the updated row
	assign need_up = (cmd_q == CMD_ADD) && (FREE_W'(id_q) == first_free_q)
		&& (up_cand == '0) && (row != ROW_W'(LAST_ROW));
	assign need_dn = (cmd_q == CMD_DEL) && present && (id_q == last_used_q)
		&& (dn_cand == '0) && (row != '0);

	// row walk
	assign scan_cand = scan_up_q ? (~rword & range_mask(scan_row_q)) : rword;
	assign scan_next = scan_up_q ? (scan_row_q + ROW_W'(1)) : (scan_row_q - ROW_W'(1));
	assign scan_end  = (scan_cand != '0)
		|| (scan_up_q && (scan_row_q == ROW_W'(LAST_ROW)))
		|| (!scan_up_q && (scan_row_q == '0));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = in_range ? ST_OP : ST_DONE;
				end
			end
			ST_OP: begin
				state_d = (need_up || need_dn) ? ST_SCAN : ST_DONE;
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs and ram read address
	always_comb begin
		busy  = 1'b1;
		done  = 1'b0;
		we    = 1'b0;
		raddr = scan_next;
		case (state_q)
			ST_IDLE: begin
				busy  = 1'b0;
				raddr = ROW_W'(item_id >> BIT_W);
			end
			ST_OP: begin
				we    = (cmd_q == CMD_ADD) || present;
				raddr = (cmd_q == CMD_ADD) ? (row + ROW_W'(1)) : (row - ROW_W'(1));
			end
			ST_SCAN: begin
				raddr = scan_next;
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	iot_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ROWS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(row),
		.wdata(wword),
		.raddr(raddr),
		.rdata(rdata)
	);

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_vld_q    <= '0;
			vld_rd_q     <= 1'b0;
			first_free_q <= FREE_W'(1);
			last_used_q  <= '0;
		end else begin
			state_q  <= state_d;
			vld_rd_q <= row_vld_q[raddr];
			if (we) begin
				row_vld_q[row] <= 1'b1;
			end
			case (state_q)
				ST_OP: begin
					if (cmd_q == CMD_ADD) begin
						if (id_q > last_used_q) begin
							last_used_q <= id_q;
						end
						if (FREE_W'(id_q) == first_free_q) begin
							if (up_cand != '0) begin
								first_free_q <= FREE_W'({row, lowest_set(up_cand)});
							end else if (row == ROW_W'(LAST_ROW)) begin
								first_free_q <= FREE_W'(MAX_ID + 1);
							end
						end
					end else if (present) begin
						if (FREE_W'(id_q) < first_free_q) begin
							first_free_q <= FREE_W'(id_q);
						end
						if (id_q == last_used_q) begin
							if (dn_cand != '0) begin
								last_used_q <= ID_W'({row, highest_set(dn_cand)});
							end else if (row == '0) begin
								last_used_q <= '0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_up_q) begin
						if (scan_cand != '0) begin
							first_free_q <= FREE_W'({scan_row_q, lowest_set(scan_cand)});
						end else if (scan_row_q == ROW_W'(LAST_ROW)) begin
							first_free_q <= FREE_W'(MAX_ID + 1);
						end
					end else begin
						if (scan_cand != '0) begin
							last_used_q <= ID_W'({scan_row_q, highest_set(scan_cand)});
						end else if (scan_row_q == '0) begin
							last_used_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request capture, status and scan position
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q         <= command;
					id_q          <= item_id;
					status_q      <= in_range ? STAT_OK : STAT_RANGE;
					was_present_q <= 1'b0;
				end
			end
			ST_OP: begin
				was_present_q <= present;
				if ((cmd_q == CMD_DEL) && !present) begin
					status_q <= STAT_ABSENT;
				end
				scan_up_q  <= (cmd_q == CMD_ADD);
				scan_row_q <= raddr;
			end
			ST_SCAN: begin
				scan_row_q <= scan_next;
			end
			default: begin
			end
		endcase
	end

	assign status       = status_q;
	assign was_present  = was_present_q;
	assign lowest_free  = first_free_q;
	assign highest_used = last_used_q;

endmodule

>>> rtl/core/iot_ram.sv
module iot_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
